>>> hdl/fprq_pkg.sv
package fprq_pkg;

   // field widths of a transaction
   localparam int CMD_W    = 2;
   localparam int ID_W     = 6;
   localparam int LVL_W    = 2;
   localparam int TIME_W   = 16;
   localparam int STATUS_W = 2;

   // priority levels
   localparam int NUM_LEVELS = 3;
   localparam logic [LVL_W-1:0] LEVEL_LOW  = 2'd0;
   localparam logic [LVL_W-1:0] LEVEL_MID  = 2'd1;
   localparam logic [LVL_W-1:0] LEVEL_HIGH = 2'd2;
   localparam logic [LVL_W-1:0] LEVEL_OVER = 2'd3;

   // command codes
   localparam logic [CMD_W-1:0] CMD_ENQUEUE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DEQUEUE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REQUEUE = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   // result of one transaction, before the store read data is merged in
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     thread_id;
      logic [LVL_W-1:0]    level;
      logic                changed;
      logic                from_store;
   } fprq_result_type;

endpackage

>>> hdl/fprq_store.sv
module fprq_store #(
   parameter int LEVEL_DEPTH = 16,
   localparam int PTR_W = $clog2(LEVEL_DEPTH)
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [fprq_pkg::LVL_W-1:0]  wr_level,
   input  logic [PTR_W-1:0]            wr_ptr,
   input  logic [fprq_pkg::ID_W-1:0]   wr_data,
   input  logic                        rd_en,
   input  logic [fprq_pkg::LVL_W-1:0]  rd_level,
   input  logic [PTR_W-1:0]            rd_ptr,
   output logic [fprq_pkg::ID_W-1:0]   rd_data
);
   import fprq_pkg::*;

   // one row of slots per level
   logic [ID_W-1:0] slots [NUM_LEVELS][LEVEL_DEPTH];
   logic [ID_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slots[wr_level][wr_ptr] <= wr_data;
      end
   end

   // registered read port, holds while no new read comes
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= slots[rd_level][rd_ptr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/fprq_ctrl.sv
module fprq_ctrl #(
   parameter int LEVEL_DEPTH = 16,
   localparam int PTR_W = $clog2(LEVEL_DEPTH),
   localparam int CNT_W = $clog2(LEVEL_DEPTH + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [fprq_pkg::CMD_W-1:0]    command,
   input  logic [fprq_pkg::ID_W-1:0]     thread_id,
   input  logic [fprq_pkg::LVL_W-1:0]    priority_in,
   input  logic [fprq_pkg::TIME_W-1:0]   time_used,
   input  logic [fprq_pkg::TIME_W-1:0]   quantum_ticks,
   output fprq_pkg::fprq_result_type     result,
   output logic                          wr_en,
   output logic [fprq_pkg::LVL_W-1:0]    wr_level,
   output logic [PTR_W-1:0]              wr_ptr,
   output logic                          rd_en,
   output logic [fprq_pkg::LVL_W-1:0]    rd_level,
   output logic [PTR_W-1:0]              rd_ptr
);
   import fprq_pkg::*;

   logic [PTR_W-1:0] head_ff  [NUM_LEVELS];
   logic [PTR_W-1:0] tail_ff  [NUM_LEVELS];
   logic [CNT_W-1:0] count_ff [NUM_LEVELS];

   logic [LVL_W-1:0] pri_sat;
   logic [LVL_W-1:0] new_pri;
   logic [LVL_W-1:0] push_level;
   logic [LVL_W-1:0] deq_level;
   logic             any_queued;
   logic             level_full;
   logic             push_ok;
   logic             deq_ok;

   function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] nxt;
      if (ptr == PTR_W'(LEVEL_DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = ptr + 1'b1;
      end
      return nxt;
   endfunction

   // priority saturation and feedback adjust
   always_comb begin
      pri_sat = (priority_in == LEVEL_OVER) ? LEVEL_HIGH : priority_in;
      if (time_used < quantum_ticks) begin
         new_pri = (pri_sat == LEVEL_HIGH) ? LEVEL_HIGH : pri_sat + 1'b1;
      end else begin
         new_pri = (pri_sat == LEVEL_LOW) ? LEVEL_LOW : pri_sat - 1'b1;
      end
      push_level = (command == CMD_REQUEUE) ? new_pri : pri_sat;
      level_full = (count_ff[push_level] == CNT_W'(LEVEL_DEPTH));
   end

   // highest non-empty level for a dequeue
   always_comb begin
      any_queued = 1'b1;
      if (count_ff[LEVEL_HIGH] != '0) begin
         deq_level = LEVEL_HIGH;
      end else if (count_ff[LEVEL_MID] != '0) begin
         deq_level = LEVEL_MID;
      end else begin
         deq_level  = LEVEL_LOW;
         any_queued = (count_ff[LEVEL_LOW] != '0);
      end
   end

   // command decode and result fields
   always_comb begin
      result  = '0;
      push_ok = 1'b0;
      deq_ok  = 1'b0;
      unique case (command) inside
         CMD_ENQUEUE, CMD_REQUEUE: begin
            push_ok          = !level_full;
            result.status    = level_full ? STATUS_FULL : STATUS_DONE;
            result.thread_id = thread_id;
            result.level     = push_level;
            result.changed   = (command == CMD_REQUEUE) && (new_pri != pri_sat);
         end
         CMD_DEQUEUE: begin
            deq_ok            = any_queued;
            result.status     = any_queued ? STATUS_DONE : STATUS_EMPTY;
            result.level      = any_queued ? deq_level : LEVEL_LOW;
            result.from_store = any_queued;
         end
         default: begin
            result = '0;
         end
      endcase
   end

   // store access
   assign wr_en    = accept && push_ok;
   assign wr_level = push_level;
   assign wr_ptr   = tail_ff[push_level];
   assign rd_en    = accept && deq_ok;
   assign rd_level = deq_level;
   assign rd_ptr   = head_ff[deq_level];

   // per-level pointers and fill counts
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int l = 0; l < NUM_LEVELS; l++) begin
            head_ff[l]  <= '0;
            tail_ff[l]  <= '0;
            count_ff[l] <= '0;
         end
      end else begin
         if (wr_en) begin
            tail_ff[push_level]  <= wrap_inc(tail_ff[push_level]);
            count_ff[push_level] <= count_ff[push_level] + 1'b1;
         end
         if (rd_en) begin
            head_ff[deq_level]  <= wrap_inc(head_ff[deq_level]);
            count_ff[deq_level] <= count_ff[deq_level] - 1'b1;
         end
      end
   end

endmodule

>>> hdl/feedback_priority_ready_queue_top.sv
// Three-level feedback ready queue of thread ids.
// Request channel (req_*): command, thread id, current priority and, for a
// requeue, the time used and the quantum. Response channel (rsp_*): status,
// thread id, priority and a priority-changed flag. Both are valid/ready.
// Every request transaction gives exactly one response transaction.
// Enqueue appends the id to the FIFO of its priority; dequeue pops the oldest
// id of the highest non-empty level; requeue moves the priority up one when
// the time used is below the quantum, else down one (clamped), then enqueues.
// The response is valid in the cycle after the request is taken.
// Throughput: one transaction per cycle while responses are taken. Pointer
// and count update, the level select and the slot memory access all happen
// as the request is taken; the dequeued id comes from the registered read
// port of the slot memory. Reset empties all three levels at once; slot
// contents are not cleared. When the receiver stalls, the response register
// holds and req_ready drops until the response is taken; a new request is
// taken in the same cycle the waiting response leaves.
module feedback_priority_ready_queue_top #(
   parameter int LEVEL_DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [fprq_pkg::CMD_W-1:0]          req_command,
   input  logic [fprq_pkg::ID_W-1:0]           req_thread_id,
   input  logic [fprq_pkg::LVL_W-1:0]          req_priority_in,
   input  logic [fprq_pkg::TIME_W-1:0]         req_time_used,
   input  logic [fprq_pkg::TIME_W-1:0]         req_quantum_ticks,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [fprq_pkg::STATUS_W-1:0]       rsp_status,
   output logic [fprq_pkg::ID_W-1:0]           rsp_thread_out,
   output logic [fprq_pkg::LVL_W-1:0]          rsp_priority_out,
   output logic                                rsp_priority_changed
);
   import fprq_pkg::*;

   localparam int PTR_W = $clog2(LEVEL_DEPTH);

   logic              accept;
   fprq_result_type   result;
   fprq_result_type   result_ff;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic              wr_en;
   logic [LVL_W-1:0]  wr_level;
   logic [PTR_W-1:0]  wr_ptr;
   logic              rd_en;
   logic [LVL_W-1:0]  rd_level;
   logic [PTR_W-1:0]  rd_ptr;
   logic [ID_W-1:0]   rd_data;

   // take a request whenever the response register is free or draining
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   fprq_ctrl #(.LEVEL_DEPTH(LEVEL_DEPTH)) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .command       (req_command),
      .thread_id     (req_thread_id),
      .priority_in   (req_priority_in),
      .time_used     (req_time_used),
      .quantum_ticks (req_quantum_ticks),
      .result        (result),
      .wr_en         (wr_en),
      .wr_level      (wr_level),
      .wr_ptr        (wr_ptr),
      .rd_en         (rd_en),
      .rd_level      (rd_level),
      .rd_ptr        (rd_ptr)
   );

   fprq_store #(.LEVEL_DEPTH(LEVEL_DEPTH)) u_store (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_level (wr_level),
      .wr_ptr   (wr_ptr),
      .wr_data  (req_thread_id),
      .rd_en    (rd_en),
      .rd_level (rd_level),
      .rd_ptr   (rd_ptr),
      .rd_data  (rd_data)
   );

   // response register
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         result_ff <= result;
      end
   end

   // dequeued ids come straight from the store read register
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = result_ff.status;
   assign rsp_thread_out       = result_ff.from_store ? rd_data : result_ff.thread_id;
   assign rsp_priority_out     = result_ff.level;
   assign rsp_priority_changed = result_ff.changed;

   // a taken request always leaves a response behind
   assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("request taken without a response");

   // empty dequeue answers with zero id and level
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_EMPTY) |->
         (rsp_thread_out == '0 && rsp_priority_out == LEVEL_LOW && !rsp_priority_changed))
      else $error("empty dequeue with nonzero fields");

   // a response never carries the out-of-range level
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_priority_out != LEVEL_OVER))
      else $error("response level out of range");

   // a store read happens only for an accepted dequeue
   assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (accept && req_command == CMD_DEQUEUE && !wr_en))
      else $error("store read outside a dequeue");

endmodule
